@@ rtl/core/tna_pkg.sv @@
// Shared constants, codes and types for the tagged natural ALU core.
`default_nettype none

package tna_pkg;

   localparam int WORD_BITS = 32;
   localparam int VAL_BITS  = WORD_BITS - 1;
   localparam int PORT_BITS = 32;

   localparam logic [2:0] KIND_ADD     = 3'd0;
   localparam logic [2:0] KIND_SUB     = 3'd1;
   localparam logic [2:0] KIND_DIVMOD  = 3'd2;
   localparam logic [2:0] KIND_EQUAL   = 3'd3;
   localparam logic [2:0] KIND_LESS    = 3'd4;
   localparam logic [2:0] KIND_GREATER = 3'd5;

   localparam logic [1:0] OUT_VALUE       = 2'd0;
   localparam logic [1:0] OUT_EMPTY       = 2'd1;
   localparam logic [1:0] OUT_UNSUPPORTED = 2'd2;

   typedef struct packed {
      logic [1:0]           outcome;
      logic [WORD_BITS-1:0] first;
      logic                 is_div;
   } side_type;

endpackage

`default_nettype wire

@@ rtl/core/tagged_natural_alu_core.sv @@
// Top level of the tagged natural ALU: operand decode, divider pipeline and output register.
`default_nettype none

// Every beat passes through one decode stage, WORD_BITS-1 divider stages and one output
// stage, and a new beat may be accepted in every cycle while req_stall is low. The whole
// pipeline moves as one: while a finished result waits under rsp_stall, req_stall is
// raised and nothing moves.
module tagged_natural_alu_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [2:0]                     req_kind,
   input  wire logic [tna_pkg::PORT_BITS-1:0]  req_operand_a,
   input  wire logic [tna_pkg::PORT_BITS-1:0]  req_operand_b,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [1:0]                          rsp_outcome,
   output logic [tna_pkg::PORT_BITS-1:0]       rsp_result_first,
   output logic [tna_pkg::PORT_BITS-1:0]       rsp_result_second
);
   import tna_pkg::*;

   logic                 advance;
   logic [WORD_BITS-1:0] wa;
   logic [WORD_BITS-1:0] wb;
   logic [VAL_BITS-1:0]  va;
   logic [VAL_BITS-1:0]  vb;
   logic [VAL_BITS:0]    sum;
   logic [VAL_BITS:0]    diff;
   side_type             side;

   logic                 div_valid;
   side_type             div_side;
   logic [VAL_BITS-1:0]  div_quotient;
   logic [VAL_BITS-1:0]  div_remainder;

   logic                 rsp_valid_ff;
   logic [1:0]           outcome_ff;
   logic [WORD_BITS-1:0] first_ff;
   logic [WORD_BITS-1:0] second_ff;
   logic [WORD_BITS-1:0] first_in;
   logic [WORD_BITS-1:0] second_in;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   always_comb begin
      wa   = req_operand_a[WORD_BITS-1:0];
      wb   = req_operand_b[WORD_BITS-1:0];
      va   = wa[VAL_BITS-1:0];
      vb   = wb[VAL_BITS-1:0];
      sum  = {1'b0, va} + {1'b0, vb};
      diff = {1'b0, va} - {1'b0, vb};
      side = '{outcome: OUT_UNSUPPORTED, first: '0, is_div: 1'b0};
      if (wa[WORD_BITS-1] && wb[WORD_BITS-1]) begin
         case (req_kind)
            KIND_ADD: begin
               if (!sum[VAL_BITS]) begin
                  side.outcome = OUT_VALUE;
                  side.first   = {1'b1, sum[VAL_BITS-1:0]};
               end
            end
            KIND_SUB: begin
               if (diff[VAL_BITS]) begin
                  side.outcome = OUT_EMPTY;
               end else begin
                  side.outcome = OUT_VALUE;
                  side.first   = {1'b1, diff[VAL_BITS-1:0]};
               end
            end
            KIND_DIVMOD: begin
               if (vb == '0) begin
                  side.outcome = OUT_EMPTY;
               end else begin
                  side.outcome = OUT_VALUE;
                  side.is_div  = 1'b1;
               end
            end
            KIND_EQUAL: begin
               side.outcome = (wa == wb) ? OUT_VALUE : OUT_EMPTY;
            end
            KIND_LESS: begin
               side.outcome = (wa < wb) ? OUT_VALUE : OUT_EMPTY;
            end
            KIND_GREATER: begin
               side.outcome = (wa > wb) ? OUT_VALUE : OUT_EMPTY;
            end
            default: begin
               side.outcome = OUT_UNSUPPORTED;
            end
         endcase
      end
   end

   tna_divider u_divider (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .in_valid      (req_valid),
      .in_side       (side),
      .in_dividend   (va),
      .in_divisor    (vb),
      .out_valid     (div_valid),
      .out_side      (div_side),
      .out_quotient  (div_quotient),
      .out_remainder (div_remainder)
   );

   always_comb begin
      if (div_side.is_div) begin
         first_in  = {1'b1, div_quotient};
         second_in = {1'b1, div_remainder};
      end else begin
         first_in  = div_side.first;
         second_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         outcome_ff <= div_side.outcome;
         first_ff   <= first_in;
         second_ff  <= second_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_outcome       = outcome_ff;
   assign rsp_result_first  = PORT_BITS'(first_ff);
   assign rsp_result_second = PORT_BITS'(second_ff);

`ifndef NO_ASSERTIONS
   a_stall_holds_input : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("Input taken while the output beat is held.");

   a_zero_when_not_value : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome != OUT_VALUE |->
         rsp_result_first == '0 && rsp_result_second == '0)
      else $error("Non-value outcome carries nonzero results.");

   a_remainder_tagged : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_second != '0 |->
         rsp_result_first[WORD_BITS-1] && rsp_result_second[WORD_BITS-1]
         && rsp_outcome == OUT_VALUE)
      else $error("Remainder present without tagged quotient.");
`endif

endmodule

`default_nettype wire

@@ rtl/core/tna_divider.sv @@
// Restoring divider pipeline, one quotient bit per stage, with sideband carried along.
`default_nettype none

module tna_divider (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic                          in_valid,
   input  wire tna_pkg::side_type             in_side,
   input  wire logic [tna_pkg::VAL_BITS-1:0]  in_dividend,
   input  wire logic [tna_pkg::VAL_BITS-1:0]  in_divisor,
   output logic                               out_valid,
   output tna_pkg::side_type                  out_side,
   output logic [tna_pkg::VAL_BITS-1:0]       out_quotient,
   output logic [tna_pkg::VAL_BITS-1:0]       out_remainder
);
   import tna_pkg::*;

   logic                valid_ff [0:VAL_BITS];
   side_type            side_ff  [0:VAL_BITS];
   logic [VAL_BITS-1:0] rem_ff   [0:VAL_BITS];
   logic [VAL_BITS-1:0] qd_ff    [0:VAL_BITS];
   logic [VAL_BITS-1:0] div_ff   [0:VAL_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= in_side;
         rem_ff[0]  <= '0;
         qd_ff[0]   <= in_dividend;
         div_ff[0]  <= in_divisor;
      end
   end

   for (genvar k = 0; k < VAL_BITS; k++) begin : g_step
      logic [VAL_BITS:0]   trial_in;
      logic [VAL_BITS:0]   diff_in;
      logic [VAL_BITS-1:0] rem_in;
      logic [VAL_BITS-1:0] qd_in;

      // A clear top bit of the difference means the divisor fits this step.
      always_comb begin
         trial_in = {rem_ff[k], qd_ff[k][VAL_BITS-1]};
         diff_in  = trial_in - {1'b0, div_ff[k]};
         rem_in   = diff_in[VAL_BITS] ? trial_in[VAL_BITS-1:0] : diff_in[VAL_BITS-1:0];
         qd_in    = {qd_ff[k][VAL_BITS-2:0], ~diff_in[VAL_BITS]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            side_ff[k+1] <= side_ff[k];
            rem_ff[k+1]  <= rem_in;
            qd_ff[k+1]   <= qd_in;
            div_ff[k+1]  <= div_ff[k];
         end
      end
   end

   assign out_valid     = valid_ff[VAL_BITS];
   assign out_side      = side_ff[VAL_BITS];
   assign out_quotient  = qd_ff[VAL_BITS];
   assign out_remainder = rem_ff[VAL_BITS];

`ifndef NO_ASSERTIONS
   a_rem_below_divisor : assert property (@(posedge clock) disable iff (reset)
      out_valid && out_side.is_div |-> out_remainder < div_ff[VAL_BITS])
      else $error("Remainder is not below the divisor.");

   a_div_nonzero : assert property (@(posedge clock) disable iff (reset)
      out_valid && out_side.is_div |-> div_ff[VAL_BITS] != '0)
      else $error("Divide beat reached the end with a zero divisor.");

   a_reset_clears : assert property (@(posedge clock)
      reset |=> !valid_ff[0] && !out_valid)
      else $error("Valid bits not cleared by reset.");
`endif

endmodule

`default_nettype wire
